### design/rspe_pkg.sv
// Package with the GF(256) arithmetic and generator constants for the Reed-Solomon parity encoder.
package rspe_pkg;

  // One codeword of the field.
  typedef logic [7:0] byte_t;

  // Field polynomial x^8+x^4+x^3+x^2+1, including the x^8 term.
  localparam logic [8:0] GF_POLY = 9'h11D;

  // Supported range of the parity length and its default.
  localparam int unsigned MAX_PARITY_LEN = 63;
  localparam int unsigned PARITY_LEN_DEF = 26;

  // Generator coefficients, index 0 multiplies the highest-order remainder byte.
  typedef byte_t [MAX_PARITY_LEN-1:0] coef_vec_t;

  // Carry-less multiply of two field elements, reduced by the field polynomial.
  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    logic [8:0] x;
    byte_t      acc;
    x   = {1'b0, a};
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return acc;
  endfunction

  // Expand the product of (x - alpha^k) for k = 0 .. n-1, leading one dropped.
  function automatic coef_vec_t gen_coefs(input int unsigned n);
    coef_vec_t c;
    byte_t     root;
    c        = '0;
    c[n-1]   = 8'h01;
    root     = 8'h01;
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned j = 0; j < n; j++) begin
        c[j] = gf_mul(c[j], root);
        if (j + 1 < n) begin
          c[j] = c[j] ^ c[j+1];
        end
      end
      root = gf_mul(root, 8'h02);
    end
    return c;
  endfunction

endpackage

### design/reed_solomon_parity_encoder.sv
// Systematic Reed-Solomon parity encoder over GF(256) with a fixed generator polynomial.
//
// Usage: data codewords enter on the in_ stream, one per transfer, with in_tlast set on the
// final codeword of a message. Every codeword comes back unchanged on the out_ stream with
// out_tuser low. After the final one, PARITY_LEN parity codewords follow, highest order
// first, with out_tuser high and out_tlast high on the last parity codeword only.
// An accepted codeword passes through the input register and then the output register.
// Throughput: one codeword per cycle while out_tready is high and no parity drains; a message
// of K codewords yields K + PARITY_LEN output codewords. While parity drains from the remainder,
// the input register can still take one codeword and then holds it until the parity is gone.
// The remainder update is one layer of constant field multipliers and an XOR per byte.
// Reset clears the remainder, the drain counter and both stage valid flags, so the first
// codeword after reset starts a fresh message. When the receiver holds out_tready low the
// output register keeps its codeword, the remainder does not move, and in_tready drops once
// the input register is also full.
module reed_solomon_parity_encoder #(
  parameter int unsigned PARITY_LEN = rspe_pkg::PARITY_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_data
  // Result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] code_byte
  output logic       out_tuser,  // [0] is_parity
  output logic       out_tlast   // end_of_block
);

  localparam int unsigned CNT_W = $clog2(PARITY_LEN + 1);
  localparam rspe_pkg::coef_vec_t GEN_COEF = rspe_pkg::gen_coefs(PARITY_LEN);

  // Input register stage.
  logic                          in_valid_r;
  rspe_pkg::byte_t               in_data_r;
  logic                          in_last_r;

  // Remainder and parity drain counter.
  rspe_pkg::byte_t [PARITY_LEN-1:0] rem_r;
  rspe_pkg::byte_t [PARITY_LEN-1:0] rem_nxt;
  rspe_pkg::byte_t [PARITY_LEN-1:0] rem_shift;
  rspe_pkg::byte_t [PARITY_LEN-1:0] rem_upd;
  logic [CNT_W-1:0]              drain_cnt_r;
  logic [CNT_W-1:0]              drain_cnt_nxt;

  // Output register stage.
  logic                          out_valid_r;
  rspe_pkg::byte_t               out_data_r;
  logic                          out_parity_r;
  logic                          out_eob_r;

  logic                          out_free;
  logic                          draining;
  logic                          move;
  rspe_pkg::byte_t               factor;

  assign out_free  = !out_valid_r || out_tready;
  assign draining  = (drain_cnt_r != '0);
  assign move      = out_free && !draining && in_valid_r;
  assign in_tready = !in_valid_r || move;
  assign factor    = in_data_r ^ rem_r[0];

  // Remainder shifted toward index 0 with a zero fill, then folded with the feedback byte.
  for (genvar g = 0; g < PARITY_LEN; g++) begin : g_rem
    localparam rspe_pkg::byte_t COEF = GEN_COEF[g];
    if (g < PARITY_LEN - 1) begin : g_mid
      assign rem_shift[g] = rem_r[g+1];
    end else begin : g_end
      assign rem_shift[g] = '0;
    end
    assign rem_upd[g] = rem_shift[g] ^ rspe_pkg::gf_mul(COEF, factor);
  end

  // Next remainder and drain count; shifting the parity out leaves the remainder cleared.
  always_comb begin
    rem_nxt       = rem_r;
    drain_cnt_nxt = drain_cnt_r;
    if (out_free && draining) begin
      rem_nxt       = rem_shift;
      drain_cnt_nxt = drain_cnt_r - CNT_W'(1);
    end else if (move) begin
      rem_nxt = rem_upd;
      if (in_last_r) begin
        drain_cnt_nxt = CNT_W'(PARITY_LEN);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      drain_cnt_r <= '0;
      rem_r       <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= draining || in_valid_r;
      end
      drain_cnt_r <= drain_cnt_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (out_free && draining) begin
      out_data_r   <= rem_r[0];
      out_parity_r <= 1'b1;
      out_eob_r    <= (drain_cnt_r == CNT_W'(1));
    end else if (move) begin
      out_data_r   <= in_data_r;
      out_parity_r <= 1'b0;
      out_eob_r    <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_parity_r;
  assign out_tlast  = out_eob_r;

  // The end-of-block mark only ever rides on a parity codeword.
  a_eob_is_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eob_r |-> out_parity_r)
    else $error("end of block on a data codeword");

  // While parity is pending the output register always holds a codeword.
  a_drain_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    draining |-> out_valid_r)
    else $error("parity pending with empty output register");

  // Loading the final parity codeword leaves the remainder cleared.
  a_rem_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_free && (drain_cnt_r == CNT_W'(1)) |=> (rem_r == '0))
    else $error("remainder not cleared after parity");

  // No data codeword moves forward while parity is still draining.
  a_no_move_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    draining && in_valid_r |-> !in_tready)
    else $error("input accepted over a held codeword during drain");

endmodule

### test/reed_solomon_parity_encoder_tb.sv
// Self-checking testbench for the Reed-Solomon parity encoder: directed and random messages.

module reed_solomon_parity_encoder_tb;

  localparam int unsigned PAR_LEN        = rspe_pkg::PARITY_LEN_DEF;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          PHASE_ITEMS    = 88;
  localparam int          MAX_REPORTS    = 10;

  // One codeword on the result stream.
  typedef struct packed {
    rspe_pkg::byte_t code;
    logic            parity;
    logic            eob;
  } codeword_t;

  // One row of the directed stimulus; zero_par marks an all-zero message.
  typedef struct packed {
    rspe_pkg::byte_t data;
    logic            last;
    logic            zero_par;
  } dir_row_t;

  localparam int DIR_N = 19;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // Single-byte message of zero right after reset.
    '{8'h00, 1'b1, 1'b1},
    // Three-byte message of zeros.
    '{8'h00, 1'b0, 1'b1}, '{8'h00, 1'b0, 1'b1}, '{8'h00, 1'b1, 1'b1},
    // Single-byte messages at the field extremes.
    '{8'h01, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b0}, '{8'h80, 1'b1, 1'b0},
    // Alternating bit patterns.
    '{8'h55, 1'b0, 1'b0}, '{8'hAA, 1'b0, 1'b0}, '{8'h0F, 1'b0, 1'b0}, '{8'hF0, 1'b1, 1'b0},
    // All ones.
    '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b0},
    // Counting pattern.
    '{8'h12, 1'b0, 1'b0}, '{8'h34, 1'b0, 1'b0}, '{8'h56, 1'b0, 1'b0}, '{8'h78, 1'b1, 1'b0}
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  // Field tables, generator and running remainder of the encoder model.
  rspe_pkg::byte_t gf_exp [0:509];
  int              gf_log [0:255];
  rspe_pkg::byte_t gen_coef [PAR_LEN];
  rspe_pkg::byte_t rem_bytes [PAR_LEN];

  codeword_t pending_codewords [$];
  int        mismatch_cnt = 0;
  int        idle_run     = 0;
  int        tx_idle_pct  = 37;
  int        rx_idle_pct  = 68;

  reed_solomon_parity_encoder #(
    .PARITY_LEN(PAR_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Field product through the log and antilog tables.
  function automatic rspe_pkg::byte_t gf_times(input rspe_pkg::byte_t a,
                                               input rspe_pkg::byte_t b);
    if (a == 8'h00 || b == 8'h00) begin
      return 8'h00;
    end
    return gf_exp[gf_log[a] + gf_log[b]];
  endfunction

  // Fold one data codeword into the remainder and queue the codewords it produces.
  task automatic encode_codeword(input rspe_pkg::byte_t d, input logic last,
                                 input logic zero_par);
    rspe_pkg::byte_t factor;
    codeword_t       cw;
    factor = d ^ rem_bytes[0];
    for (int i = 0; i < PAR_LEN - 1; i++) begin
      rem_bytes[i] = rem_bytes[i+1] ^ gf_times(gen_coef[i], factor);
    end
    rem_bytes[PAR_LEN-1] = gf_times(gen_coef[PAR_LEN-1], factor);
    cw = '{code: d, parity: 1'b0, eob: 1'b0};
    pending_codewords.push_back(cw);
    if (last) begin
      for (int i = 0; i < PAR_LEN; i++) begin
        cw.code   = zero_par ? 8'h00 : rem_bytes[i];
        cw.parity = 1'b1;
        cw.eob    = (i == PAR_LEN - 1);
        pending_codewords.push_back(cw);
      end
      for (int i = 0; i < PAR_LEN; i++) begin
        rem_bytes[i] = 8'h00;
      end
    end
  endtask

  // Offer one codeword on the input stream, then predict once the transfer happens.
  task automatic send_codeword(input rspe_pkg::byte_t d, input logic last,
                               input logic zero_par);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    do begin
      @(posedge clk);
    end while (!in_tready);
    encode_codeword(d, last, zero_par);
  endtask

  // Count a failure and report the first few.
  function automatic void note_mismatch(input string what, input codeword_t exp_cw,
                                        input codeword_t got_cw);
    if (mismatch_cnt < MAX_REPORTS) begin
      $display("mismatch (%s): expected code %02h parity %0d end %0d,", what,
               exp_cw.code, exp_cw.parity, exp_cw.eob);
      $display("  got code %02h parity %0d end %0d",
               got_cw.code, got_cw.parity, got_cw.eob);
    end
    mismatch_cnt++;
  endfunction

  // Receiver readiness, stalled at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Result checking and the watchdog on transfers.
  always @(posedge clk) begin
    codeword_t got_cw;
    codeword_t exp_cw;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_cw = '{code: out_tdata, parity: out_tuser, eob: out_tlast};
        if (pending_codewords.size() == 0) begin
          note_mismatch("unexpected", '0, got_cw);
        end else begin
          exp_cw = pending_codewords.pop_front();
          if (got_cw.code != exp_cw.code) begin
            note_mismatch("code", exp_cw, got_cw);
          end else if (got_cw.parity != exp_cw.parity) begin
            note_mismatch("parity flag", exp_cw, got_cw);
          end else if (got_cw.eob != exp_cw.eob) begin
            note_mismatch("end of block", exp_cw, got_cw);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_run <= 0;
      end else if (idle_run >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // Stimulus: field tables, reset, directed rows, random messages, drain.
  initial begin
    logic [8:0]      t;
    rspe_pkg::byte_t g [PAR_LEN+1];
    rspe_pkg::byte_t root;
    rspe_pkg::byte_t d;
    int              len;
    int              pattern;
    int              sent;

    // Antilog and log tables of the field.
    t = 9'h001;
    for (int i = 0; i < 255; i++) begin
      gf_exp[i]       = t[7:0];
      gf_exp[i + 255] = t[7:0];
      gf_log[t[7:0]]  = i;
      t = {t[7:0], 1'b0};
      if (t[8]) begin
        t = t ^ rspe_pkg::GF_POLY;
      end
    end
    gf_log[0] = 0;

    // Generator as the product of (x + alpha^k); g[n] holds the x^n coefficient.
    for (int i = 0; i <= PAR_LEN; i++) begin
      g[i] = 8'h00;
    end
    g[0] = 8'h01;
    for (int k = 0; k < PAR_LEN; k++) begin
      root = gf_exp[k];
      for (int n = k + 1; n >= 1; n--) begin
        g[n] = g[n-1] ^ gf_times(g[n], root);
      end
      g[0] = gf_times(g[0], root);
    end
    for (int j = 0; j < PAR_LEN; j++) begin
      gen_coef[j]  = g[PAR_LEN-1-j];
      rem_bytes[j] = 8'h00;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows.
    for (int r = 0; r < DIR_N; r++) begin
      send_codeword(DIR_ROWS[r].data, DIR_ROWS[r].last, DIR_ROWS[r].zero_par);
    end

    // Random messages in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct = 68;
        end
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct = 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len     = ($urandom_range(7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        pattern = $urandom_range(9);
        for (int k = 0; k < len; k++) begin
          if (pattern == 0) begin
            d = 8'h00;
          end else if (pattern == 1) begin
            d = 8'hFF;
          end else begin
            d = rspe_pkg::byte_t'($urandom_range(255));
          end
          send_codeword(d, k == len - 1, 1'b0);
        end
        sent += len;
      end
    end
    in_tvalid <= 1'b0;

    // Wait for every expected codeword, then keep watching for strays.
    while (pending_codewords.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && pending_codewords.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### reed_solomon_parity_encoder.f
design/rspe_pkg.sv
design/reed_solomon_parity_encoder.sv
test/reed_solomon_parity_encoder_tb.sv
